### design/vdi_pkg.sv
package vdi_pkg;

    // table geometry
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 11;
    localparam int WORD_W       = 32;

    // configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int MODE_W       = 2;
    localparam logic [APB_ADDR_W-3:0] REG_ATTR_MODE = 1'b0;

    // attribute modes (any other code means position only)
    localparam logic [MODE_W-1:0] MODE_FULL     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS_NORM = 2'd1;

    // substituted float bit patterns
    localparam logic [WORD_W-1:0] FLOAT_ZERO = 32'h0000_0000;
    localparam logic [WORD_W-1:0] FLOAT_ONE  = 32'h3F80_0000;

    // one stored vertex
    typedef struct packed {
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
        logic [WORD_W-1:0] norm_x;
        logic [WORD_W-1:0] norm_y;
        logic [WORD_W-1:0] norm_z;
    } t_vertex;

endpackage

### design/vdi_channels.sv
// vertex request channel
interface vdi_in_if;
    logic                        valid;
    logic                        ready;
    logic                        first_of_mesh;
    logic [vdi_pkg::WORD_W-1:0]  pos_x;
    logic [vdi_pkg::WORD_W-1:0]  pos_y;
    logic [vdi_pkg::WORD_W-1:0]  pos_z;
    logic [vdi_pkg::WORD_W-1:0]  tex_u;
    logic [vdi_pkg::WORD_W-1:0]  tex_v;
    logic [vdi_pkg::WORD_W-1:0]  norm_x;
    logic [vdi_pkg::WORD_W-1:0]  norm_y;
    logic [vdi_pkg::WORD_W-1:0]  norm_z;

    modport source (
        output valid, first_of_mesh, pos_x, pos_y, pos_z,
        output tex_u, tex_v, norm_x, norm_y, norm_z,
        input  ready
    );
    modport sink (
        input  valid, first_of_mesh, pos_x, pos_y, pos_z,
        input  tex_u, tex_v, norm_x, norm_y, norm_z,
        output ready
    );
endinterface

// index result channel
interface vdi_out_if;
    logic                       valid;
    logic                       ready;
    logic [vdi_pkg::CNT_W-1:0]  vertex_index;
    logic                       is_new;
    logic                       overflow;
    logic [vdi_pkg::CNT_W-1:0]  unique_count;

    modport source (
        output valid, vertex_index, is_new, overflow, unique_count,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, is_new, overflow, unique_count,
        output ready
    );
endinterface

### design/vertex_dedup_indexer.sv
// vertex deduplication indexer
// i_vtx carries one vertex per request (position, uv, normal as raw float
// bits plus a first-of-mesh flag); o_res returns one result per request:
// the vertex index, whether it was appended, an overflow flag for a miss on
// a full table, and the unique count after the request.
// attribute_mode (apb register 0) selects which attributes take part; the
// ones left out are stored as uv (0,0) and normal (0,1,0).
// the unique table is a single-port-read memory scanned in insertion order,
// one entry per cycle through one 256-bit equality compare. a hit on entry k
// ends the scan there; a miss reads all F entries first, F being the table
// fill level, so a miss takes longest on a full table; the read port of the
// table sets that bound.
// i_vtx.ready is high only while the sequencer is idle, one request at a
// time: the next request is taken in the cycle after a result reaches the
// output register. a finished result sits in the output register; a new
// request is taken while it waits, and its own result holds until the slot
// frees.
// reset empties the table through its fill count (no clearing pass) and sets
// attribute_mode to 0; table contents are not reset.
module vertex_dedup_indexer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    vdi_in_if.sink                             i_vtx,
    vdi_out_if.source                          o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vdi_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vdi_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vdi_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int ADDR_W = vdi_pkg::ADDR_W;
    localparam int CNT_W  = vdi_pkg::CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(vdi_pkg::MAX_VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } t_state;

    // table memory
    vdi_pkg::t_vertex mem [vdi_pkg::MAX_VERTICES];

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_scan, n_scan;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0]          r_cmp_idx, n_cmp_idx;
    logic [vdi_pkg::MODE_W-1:0] r_mode, n_mode;
    vdi_pkg::t_vertex           r_vtx, n_vtx;
    vdi_pkg::t_vertex           r_rd_data;
    logic [CNT_W-1:0]           r_res_idx, n_res_idx;
    logic                       r_res_new, n_res_new;
    logic                       r_res_ovf, n_res_ovf;
    logic [CNT_W-1:0]           r_res_cnt, n_res_cnt;
    logic                       r_out_vld, n_out_vld;
    logic [CNT_W-1:0]           r_out_idx, n_out_idx;
    logic                       r_out_new, n_out_new;
    logic                       r_out_ovf, n_out_ovf;
    logic [CNT_W-1:0]           r_out_cnt, n_out_cnt;

    logic             in_acc;
    logic             cfg_wr;
    logic             rd_issue;
    logic             hit;
    logic             scan_end;
    logic             wr_en;
    logic             slot_free;
    vdi_pkg::t_vertex in_vtx;

    // handshakes
    assign i_vtx.ready = (r_state == ST_IDLE);
    assign in_acc      = i_vtx.valid && i_vtx.ready;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign slot_free   = !r_out_vld || o_res.ready;

    // register read back
    always_comb begin
        unique case (paddr[vdi_pkg::APB_ADDR_W-1:2])
            vdi_pkg::REG_ATTR_MODE: prdata = vdi_pkg::APB_DATA_W'(r_mode);
            default:                prdata = '0;
        endcase
    end

    // attribute selection on the incoming vertex
    always_comb begin
        in_vtx.pos_x = i_vtx.pos_x;
        in_vtx.pos_y = i_vtx.pos_y;
        in_vtx.pos_z = i_vtx.pos_z;
        if (r_mode == vdi_pkg::MODE_FULL) begin
            in_vtx.tex_u = i_vtx.tex_u;
            in_vtx.tex_v = i_vtx.tex_v;
        end else begin
            in_vtx.tex_u = vdi_pkg::FLOAT_ZERO;
            in_vtx.tex_v = vdi_pkg::FLOAT_ZERO;
        end
        if (r_mode == vdi_pkg::MODE_FULL || r_mode == vdi_pkg::MODE_POS_NORM) begin
            in_vtx.norm_x = i_vtx.norm_x;
            in_vtx.norm_y = i_vtx.norm_y;
            in_vtx.norm_z = i_vtx.norm_z;
        end else begin
            in_vtx.norm_x = vdi_pkg::FLOAT_ZERO;
            in_vtx.norm_y = vdi_pkg::FLOAT_ONE;
            in_vtx.norm_z = vdi_pkg::FLOAT_ZERO;
        end
    end

    // scan control: one read issued per cycle, compare in the cycle after
    assign rd_issue = (r_state == ST_SCAN) && (r_scan < r_count);
    assign hit      = (r_state == ST_SCAN) && r_cmp_vld && (r_rd_data == r_vtx);
    assign scan_end = (r_state == ST_SCAN) && !r_cmp_vld && !rd_issue;
    assign wr_en    = scan_end && (r_count < MAX_CNT);

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_scan    = r_scan;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_scan[ADDR_W-1:0];
        n_mode    = r_mode;
        n_vtx     = r_vtx;
        n_res_idx = r_res_idx;
        n_res_new = r_res_new;
        n_res_ovf = r_res_ovf;
        n_res_cnt = r_res_cnt;
        n_out_vld = r_out_vld && !o_res.ready;
        n_out_idx = r_out_idx;
        n_out_new = r_out_new;
        n_out_ovf = r_out_ovf;
        n_out_cnt = r_out_cnt;

        if (cfg_wr && paddr[vdi_pkg::APB_ADDR_W-1:2] == vdi_pkg::REG_ATTR_MODE) begin
            n_mode = pwdata[vdi_pkg::MODE_W-1:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_vtx   = in_vtx;
                    n_scan  = '0;
                    n_state = ST_SCAN;
                    if (i_vtx.first_of_mesh) begin
                        n_count = '0;
                    end
                end
            end
            ST_SCAN: begin
                n_cmp_vld = rd_issue;
                if (rd_issue) begin
                    n_scan = r_scan + 1'b1;
                end
                if (hit) begin
                    n_res_idx = CNT_W'(r_cmp_idx);
                    n_res_new = 1'b0;
                    n_res_ovf = 1'b0;
                    n_res_cnt = r_count;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_PUSH;
                end else if (scan_end) begin
                    if (wr_en) begin
                        n_res_idx = r_count;
                        n_res_new = 1'b1;
                        n_res_ovf = 1'b0;
                        n_count   = r_count + 1'b1;
                        n_res_cnt = r_count + 1'b1;
                    end else begin
                        n_res_idx = '0;
                        n_res_new = 1'b0;
                        n_res_ovf = 1'b1;
                        n_res_cnt = r_count;
                    end
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (slot_free) begin
                    n_out_vld = 1'b1;
                    n_out_idx = r_res_idx;
                    n_out_new = r_res_new;
                    n_out_ovf = r_res_ovf;
                    n_out_cnt = r_res_cnt;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_vtx     <= n_vtx;
        r_scan    <= n_scan;
        r_cmp_idx <= n_cmp_idx;
        r_res_idx <= n_res_idx;
        r_res_new <= n_res_new;
        r_res_ovf <= n_res_ovf;
        r_res_cnt <= n_res_cnt;
        r_out_idx <= n_out_idx;
        r_out_new <= n_out_new;
        r_out_ovf <= n_out_ovf;
        r_out_cnt <= n_out_cnt;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_mode    <= vdi_pkg::MODE_FULL;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_mode    <= n_mode;
            r_out_vld <= n_out_vld;
        end
    end

    // unique table: append write and registered scan read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= r_vtx;
        end
        if (rd_issue) begin
            r_rd_data <= mem[r_scan[ADDR_W-1:0]];
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.vertex_index = r_out_idx;
    assign o_res.is_new       = r_out_new;
    assign o_res.overflow     = r_out_ovf;
    assign o_res.unique_count = r_out_cnt;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("fill count beyond table depth");

    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_new) |-> (o_res.unique_count == o_res.vertex_index + 1'b1))
        else $error("appended vertex is not the last table entry");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.overflow) |->
            (o_res.unique_count == MAX_CNT && !o_res.is_new && o_res.vertex_index == '0))
        else $error("overflow reported on a table that is not full");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (CNT_W'(r_cmp_idx) < r_count))
        else $error("match on an entry beyond the fill count");

    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && !slot_free) |=> (r_state == ST_PUSH && r_out_vld))
        else $error("result left while output slot was busy");

endmodule

### test/vdi_index_checker.sv
`timescale 1ns / 1ps

// watches the vertex and result channels plus the register port, keeps its own
// copy of the unique table and the attribute mode, and compares every result
module vdi_index_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vdi_in_if                              i_vtx,
    vdi_out_if                             i_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vdi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vdi_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int CNT_W      = vdi_pkg::CNT_W;
    localparam int MODE_W     = vdi_pkg::MODE_W;
    localparam int APB_ADDR_W = vdi_pkg::APB_ADDR_W;

    typedef struct packed {
        logic [CNT_W-1:0] vertex_index;
        logic             is_new;
        logic             overflow;
        logic [CNT_W-1:0] unique_count;
    } t_index_result;

    vdi_pkg::t_vertex  unique_table [vdi_pkg::MAX_VERTICES];
    int unsigned       entry_count;
    logic [MODE_W-1:0] attr_mode;
    t_index_result     expected_indices [$];
    int                fails = 0;

    // dedup one vertex against the table, appending on a miss while there is room
    function automatic t_index_result index_vertex(input logic first,
                                                   input vdi_pkg::t_vertex raw);
        vdi_pkg::t_vertex key;
        t_index_result    res;
        bit               hit;
        int unsigned      j;
        key = raw;
        // attributes left out by the mode take their fixed values
        if (attr_mode != vdi_pkg::MODE_FULL) begin
            key.tex_u = vdi_pkg::FLOAT_ZERO;
            key.tex_v = vdi_pkg::FLOAT_ZERO;
        end
        if (attr_mode != vdi_pkg::MODE_FULL && attr_mode != vdi_pkg::MODE_POS_NORM) begin
            key.norm_x = vdi_pkg::FLOAT_ZERO;
            key.norm_y = vdi_pkg::FLOAT_ONE;
            key.norm_z = vdi_pkg::FLOAT_ZERO;
        end
        if (first)
            entry_count = 0;
        res = '0;
        hit = 1'b0;
        // first match in insertion order wins
        for (j = 0; j < entry_count && !hit; j++) begin
            if (unique_table[j] == key) begin
                hit = 1'b1;
                res.vertex_index = CNT_W'(j);
            end
        end
        if (!hit) begin
            if (entry_count < vdi_pkg::MAX_VERTICES) begin
                unique_table[entry_count] = key;
                res.vertex_index = CNT_W'(entry_count);
                res.is_new = 1'b1;
                entry_count++;
            end else begin
                res.overflow = 1'b1;
            end
        end
        res.unique_count = CNT_W'(entry_count);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want_v,
                                        input logic [CNT_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_index_result want;
        if (!i_rst_n) begin
            entry_count = 0;
            attr_mode = vdi_pkg::MODE_FULL;
            expected_indices.delete();
        end else begin
            // mode register write
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_W-1:2] == vdi_pkg::REG_ATTR_MODE)
                attr_mode = pwdata[MODE_W-1:0];
            // result side first, so a request taken at this edge is never matched here
            if (i_res.valid && i_res.ready) begin
                if (expected_indices.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual index %0d count %0d",
                             $time, i_res.vertex_index, i_res.unique_count);
                    fails++;
                end else begin
                    want = expected_indices.pop_front();
                    check_field("vertex_index", want.vertex_index, i_res.vertex_index);
                    check_field("is_new", CNT_W'(want.is_new), CNT_W'(i_res.is_new));
                    check_field("overflow", CNT_W'(want.overflow), CNT_W'(i_res.overflow));
                    check_field("unique_count", want.unique_count, i_res.unique_count);
                end
            end
            // vertex request
            if (i_vtx.valid && i_vtx.ready)
                expected_indices.push_back(index_vertex(i_vtx.first_of_mesh,
                    {i_vtx.pos_x, i_vtx.pos_y, i_vtx.pos_z, i_vtx.tex_u, i_vtx.tex_v,
                     i_vtx.norm_x, i_vtx.norm_y, i_vtx.norm_z}));
        end
        o_fail_count <= fails;
        o_pending <= expected_indices.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MODE_W     = vdi_pkg::MODE_W;
    localparam int WORD_W     = vdi_pkg::WORD_W;
    localparam int APB_ADDR_W = vdi_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = vdi_pkg::APB_DATA_W;
    localparam logic [WORD_W-1:0] ZERO_BITS     = vdi_pkg::FLOAT_ZERO;
    localparam logic [WORD_W-1:0] ONE_BITS      = vdi_pkg::FLOAT_ONE;
    localparam logic [MODE_W-1:0] MODE_POS_ONLY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam logic [WORD_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;
    localparam int RANDOM_VERTICES = 580;
    localparam int IDLE_PCT        = 13;
    localparam int MODE_SPAN       = 120;

    typedef struct packed {
        logic             first_of_mesh;
        vdi_pkg::t_vertex vtx;
    } t_vertex_request;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    quiet_stretch = 1'b0;
    int                    fail_count;
    int                    pending;
    int                    vertices_sent = 0;

    vdi_in_if  vtx_ch ();
    vdi_out_if res_ch ();

    vertex_dedup_indexer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vdi_index_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (vtx_ch),
        .i_res        (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // result-side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    // hand one vertex request over, then maybe leave a gap
    task automatic send_vertex(input t_vertex_request req);
        vtx_ch.valid         <= 1'b1;
        vtx_ch.first_of_mesh <= req.first_of_mesh;
        vtx_ch.pos_x         <= req.vtx.pos_x;
        vtx_ch.pos_y         <= req.vtx.pos_y;
        vtx_ch.pos_z         <= req.vtx.pos_z;
        vtx_ch.tex_u         <= req.vtx.tex_u;
        vtx_ch.tex_v         <= req.vtx.tex_v;
        vtx_ch.norm_x        <= req.vtx.norm_x;
        vtx_ch.norm_y        <= req.vtx.norm_y;
        vtx_ch.norm_z        <= req.vtx.norm_z;
        @(posedge i_clk);
        while (!vtx_ch.ready) @(posedge i_clk);
        vertices_sent++;
        if (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
            vtx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_parts(input logic first,
                              input logic [WORD_W-1:0] px, py, pz, u, v, nx, ny, nz);
        send_vertex({first, px, py, pz, u, v, nx, ny, nz});
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        vtx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // two-phase register write
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {vdi_pkg::REG_ATTR_MODE, 2'b00};
        pwdata  <= {(APB_DATA_W-MODE_W)'($urandom()), mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // float words biased toward the patterns the block substitutes
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return ZERO_BITS;
            1: return ONE_BITS;
            2: return ALL_ONES;
            3: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic vdi_pkg::t_vertex rand_vertex();
        return {rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // one mesh: fresh table, vertices drawn from a small pool so hits are common
    task automatic send_mesh();
        vdi_pkg::t_vertex pool [24];
        t_vertex_request  req;
        int               pool_n;
        int               mesh_len;
        int               k;
        pool_n = $urandom_range(1, 24);
        mesh_len = $urandom_range(1, 48);
        for (k = 0; k < pool_n; k++)
            pool[k] = rand_vertex();
        for (k = 0; k < mesh_len; k++) begin
            req.first_of_mesh = (k == 0);
            req.vtx = pool[$urandom_range(pool_n - 1)];
            // attributes that some modes ignore, or a near miss on one bit
            case ($urandom_range(9))
                0: req.vtx.tex_u = $urandom();
                1: req.vtx.tex_v = rand_word();
                2: req.vtx.norm_y = rand_word();
                3: req.vtx = vdi_pkg::t_vertex'(req.vtx ^ (256'(1) << $urandom_range(255)));
                default: ;
            endcase
            send_vertex(req);
        end
    endtask

    initial begin
        t_vertex_request         req;
        logic [WORD_W-1:0]       fill_y;
        logic [WORD_W-1:0]       fill_z;
        int                      k;
        int                      random_start;
        int                      next_mode_change;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        vtx_ch.valid         <= 1'b0;
        vtx_ch.first_of_mesh <= 1'b0;
        vtx_ch.pos_x         <= '0;
        vtx_ch.pos_y         <= '0;
        vtx_ch.pos_z         <= '0;
        vtx_ch.tex_u         <= '0;
        vtx_ch.tex_v         <= '0;
        vtx_ch.norm_x        <= '0;
        vtx_ch.norm_y        <= '0;
        vtx_ch.norm_z        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode: every attribute counts
        send_parts(1'b1, ZERO_BITS, ZERO_BITS, ZERO_BITS, ZERO_BITS, ZERO_BITS,
                   ZERO_BITS, ZERO_BITS, ZERO_BITS);
        send_parts(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                   ALL_ONES, ALL_ONES, ALL_ONES);
        send_parts(1'b0, ZERO_BITS, ZERO_BITS, ZERO_BITS, ZERO_BITS, ZERO_BITS,
                   ZERO_BITS, ZERO_BITS, ZERO_BITS);
        send_parts(1'b0, ZERO_BITS, ZERO_BITS, ZERO_BITS, 32'h0000_0001, ZERO_BITS,
                   ZERO_BITS, ZERO_BITS, ZERO_BITS);
        // same bits as a later position-only vertex at the origin, which hits it
        send_parts(1'b0, ZERO_BITS, ZERO_BITS, ZERO_BITS, ZERO_BITS, ZERO_BITS,
                   ZERO_BITS, ONE_BITS, ZERO_BITS);
        send_parts(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                   ALL_ONES, ALL_ONES, ALL_ONES);

        // position and normal: uv forced to zero
        wait_drained();
        write_mode(vdi_pkg::MODE_POS_NORM);
        send_parts(1'b0, ZERO_BITS, ZERO_BITS, ZERO_BITS, $urandom(), $urandom(),
                   ZERO_BITS, ZERO_BITS, ZERO_BITS);
        send_parts(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, $urandom(), $urandom(),
                   ALL_ONES, ALL_ONES, ALL_ONES);

        // position only, then the spare code that behaves the same
        wait_drained();
        write_mode(MODE_POS_ONLY);
        send_parts(1'b0, ZERO_BITS, ZERO_BITS, ZERO_BITS, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
        send_parts(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
        wait_drained();
        write_mode(MODE_SPARE);
        send_parts(1'b0, ZERO_BITS, ZERO_BITS, ZERO_BITS, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
        send_parts(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
        send_parts(1'b1, ALL_ONES, ALL_ONES, ALL_ONES, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());

        // fill the table to the brim, then miss and hit on a full table
        wait_drained();
        write_mode(MODE_POS_ONLY);
        fill_y = $urandom();
        fill_z = $urandom();
        for (k = 0; k < vdi_pkg::MAX_VERTICES; k++)
            send_parts(k == 0, WORD_W'(k), fill_y, fill_z, $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
        send_parts(1'b0, WORD_W'(vdi_pkg::MAX_VERTICES), fill_y, fill_z, $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
        send_parts(1'b0, WORD_W'(vdi_pkg::MAX_VERTICES - 1), fill_y, fill_z, $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
        send_parts(1'b0, ZERO_BITS, fill_y, fill_z, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
        send_parts(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
        send_parts(1'b1, WORD_W'(vdi_pkg::MAX_VERTICES), fill_y, fill_z, $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
        wait_drained();
        write_mode(vdi_pkg::MODE_FULL);

        // random meshes with some loose vertices, mode changed between spans
        random_start = vertices_sent;
        next_mode_change = MODE_SPAN;
        while (vertices_sent - random_start < RANDOM_VERTICES) begin
            if (vertices_sent - random_start >= next_mode_change) begin
                wait_drained();
                write_mode(MODE_W'($urandom_range(3)));
                next_mode_change += MODE_SPAN;
            end
            quiet_stretch = (vertices_sent - random_start >= 200) &&
                            (vertices_sent - random_start < 330);
            if ($urandom_range(99) < 85) begin
                send_mesh();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    req.first_of_mesh = ($urandom_range(7) == 0);
                    req.vtx = rand_vertex();
                    send_vertex(req);
                end
            end
            if ($urandom_range(29) == 0)
                wait_drained();
        end
        quiet_stretch = 1'b0;

        wait_drained();
        repeat (1100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
design/vdi_pkg.sv
design/vdi_channels.sv
design/vertex_dedup_indexer.sv
test/vdi_index_checker.sv
test/tb.sv
